// ----- hdl/breakpoint_watch_table_unit_macros.svh -----
// assertion macros shared by the breakpoint watch table checker
// no dependencies; pulled in by bwt_checker.sv
`ifndef BREAKPOINT_WATCH_TABLE_UNIT_MACROS_SVH
`define BREAKPOINT_WATCH_TABLE_UNIT_MACROS_SVH

// same-cycle implication, off while reset is low
`define BWT_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off while reset is low
`define BWT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/bwt_pkg.sv -----
// shared types, constants and helper functions of the breakpoint watch table
// no dependencies; used by the top level and the checker
`default_nettype none

package bwt_pkg;

    localparam int unsigned ADDR_SPACE  = 65536;
    localparam int unsigned ADDR_W      = 16;
    localparam int unsigned TABLE_DEPTH = 1 << ADDR_W;
    localparam int unsigned COUNT_W     = 17;
    localparam int unsigned BIT_IDX_W   = 4;
    localparam int unsigned ROW_W       = 1 << BIT_IDX_W;
    localparam int unsigned ROWS        = TABLE_DEPTH / ROW_W;
    localparam int unsigned ROW_IDX_W   = ADDR_W - BIT_IDX_W;

    localparam logic [ADDR_W:0]    SPACE_LIMIT    = (ADDR_W + 1)'(ADDR_SPACE);
    localparam logic [ADDR_W-1:0]  LAST_ADDR      = ADDR_W'(ADDR_SPACE - 1);
    localparam logic [ROW_IDX_W-1:0] LAST_ROW     = LAST_ADDR[ADDR_W-1:BIT_IDX_W];
    localparam logic [BIT_IDX_W-1:0] LAST_BIT     = LAST_ADDR[BIT_IDX_W-1:0];
    localparam logic [ROW_IDX_W-1:0] CLEAR_LAST_ROW = ROW_IDX_W'(ROWS - 1);

    // action codes
    localparam logic [2:0] ACT_CHECK  = 3'd0;
    localparam logic [2:0] ACT_ADD    = 3'd1;
    localparam logic [2:0] ACT_REMOVE = 3'd2;
    localparam logic [2:0] ACT_NEXT   = 3'd3;
    localparam logic [2:0] ACT_PREV   = 3'd4;
    localparam logic [2:0] ACT_CLEAR  = 3'd5;

    // condition codes
    localparam logic [2:0] COND_GT     = 3'd0;
    localparam logic [2:0] COND_LT     = 3'd1;
    localparam logic [2:0] COND_GE     = 3'd2;
    localparam logic [2:0] COND_LE     = 3'd3;
    localparam logic [2:0] COND_EQ     = 3'd4;
    localparam logic [2:0] COND_NE     = 3'd5;
    localparam logic [2:0] COND_ALWAYS = 3'd6;

    typedef struct packed {
        logic [2:0]        action;
        logic [ADDR_W-1:0] address;
        logic [7:0]        access_value;
        logic [2:0]        match_condition;
        logic [7:0]        match_value;
        logic [7:0]        match_mask;
        logic [2:0]        access_types;
    } in_word_t;

    typedef struct packed {
        logic               hit;
        logic               found;
        logic [ADDR_W-1:0]  found_address;
        logic [2:0]         entry_condition;
        logic [7:0]         entry_value;
        logic [7:0]         entry_mask;
        logic [2:0]         entry_types;
        logic [COUNT_W-1:0] total_count;
        logic [COUNT_W-1:0] execute_count;
        logic [COUNT_W-1:0] read_count;
        logic [COUNT_W-1:0] write_count;
    } out_word_t;

    // one stored entry, bit 0 up: condition, value, mask, types
    typedef struct packed {
        logic [2:0] types;
        logic [7:0] mask;
        logic [7:0] value;
        logic [2:0] cond;
    } entry_t;

    localparam int unsigned ENTRY_W = $bits(entry_t);

    function automatic logic cond_holds(input entry_t e, input logic [7:0] v);
        logic [7:0] r;
        logic       h;
        r = e.value & e.mask;
        unique case (e.cond)
            COND_GT:     h = v > r;
            COND_LT:     h = v < r;
            COND_GE:     h = v >= r;
            COND_LE:     h = v <= r;
            COND_EQ:     h = v == r;
            COND_NE:     h = v != r;
            COND_ALWAYS: h = 1'b1;
            default:     h = 1'b0;
        endcase
        return h;
    endfunction

    // bits at position b and above
    function automatic logic [ROW_W-1:0] ge_mask(input logic [BIT_IDX_W-1:0] b);
        return {ROW_W{1'b1}} << b;
    endfunction

    // bits at position b and below
    function automatic logic [ROW_W-1:0] le_mask(input logic [BIT_IDX_W-1:0] b);
        return {ROW_W{1'b1}} >> (~b);
    endfunction

    function automatic logic [BIT_IDX_W-1:0] lowest_set(input logic [ROW_W-1:0] bits);
        logic [BIT_IDX_W-1:0] idx;
        idx = '0;
        for (int i = ROW_W - 1; i >= 0; i--) begin
            if (bits[i]) idx = BIT_IDX_W'(i);
        end
        return idx;
    endfunction

    function automatic logic [BIT_IDX_W-1:0] highest_set(input logic [ROW_W-1:0] bits);
        logic [BIT_IDX_W-1:0] idx;
        idx = '0;
        for (int i = 0; i < ROW_W; i++) begin
            if (bits[i]) idx = BIT_IDX_W'(i);
        end
        return idx;
    endfunction

    function automatic logic [COUNT_W-1:0] count_adjust(input logic [COUNT_W-1:0] cnt,
                                                        input logic inc, input logic dec);
        return cnt + COUNT_W'(inc) - COUNT_W'(dec);
    endfunction

endpackage

`default_nettype wire

// ----- hdl/bwt_ram.sv -----
// generic simple dual-port ram: one write port, one registered read port
// no dependencies
`default_nettype none

module bwt_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ----- hdl/breakpoint_watch_table_unit.sv -----
// top level of the breakpoint watch table: sequencer, counters, result register
// depends on bwt_pkg and bwt_ram
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+-----------------------
//   in      | input     | in_valid / in_ready  | in_word  (in_word_t)
//   out     | output    | out_valid / out_ready| out_word (out_word_t)
//
// check, add, remove and unknown actions read the entry ram and the valid-row ram when
// the word is accepted, then decide, write back and load the result in ST_OP
// next / previous search reads the valid rows one by one, 16 addresses per valid row,
// at most 4096 rows; clear writes one valid row per cycle, the last only once the result register is free
// after reset a sweep zeroes all 4096 valid rows, in_ready stays low meanwhile
// a word is accepted while the last result still waits; a stalled result holds the
// sequencer in its final step until out_ready frees the register
`default_nettype none

module breakpoint_watch_table_unit (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  bwt_pkg::in_word_t   in_word,
    output logic                out_valid,
    input  logic                out_ready,
    output bwt_pkg::out_word_t  out_word
);

    typedef enum logic [4:0] {
        ST_INIT  = 5'b00001,   // reset sweep of the valid rows
        ST_IDLE  = 5'b00010,
        ST_OP    = 5'b00100,   // check / add / remove / unknown on read data
        ST_SCAN  = 5'b01000,   // row-by-row search
        ST_CLEAR = 5'b10000    // clear sweep
    } state_t;

    state_t state_reg, state_next;

    bwt_pkg::in_word_t                  req_reg, req_next;
    logic [bwt_pkg::ROW_IDX_W-1:0]      row_reg, row_next;
    logic [bwt_pkg::BIT_IDX_W-1:0]      start_bit_reg, start_bit_next;
    logic                               first_reg, first_next;

    logic [bwt_pkg::COUNT_W-1:0] total_reg, total_next;
    logic [bwt_pkg::COUNT_W-1:0] exec_reg, exec_next;
    logic [bwt_pkg::COUNT_W-1:0] read_reg, read_next;
    logic [bwt_pkg::COUNT_W-1:0] write_reg, write_next;

    logic                out_valid_reg, out_valid_next;
    bwt_pkg::out_word_t  out_word_reg, out_word_next;
    logic                out_load;

    // entry ram ports
    logic                        data_rd_en;
    logic [bwt_pkg::ADDR_W-1:0]  data_rd_addr;
    bwt_pkg::entry_t             data_rd;
    logic                        data_wr_en;
    logic [bwt_pkg::ADDR_W-1:0]  data_wr_addr;
    bwt_pkg::entry_t             data_wr;

    // valid-row ram ports
    logic                          vld_rd_en;
    logic [bwt_pkg::ROW_IDX_W-1:0] vld_rd_addr;
    logic [bwt_pkg::ROW_W-1:0]     vld_rd;
    logic                          vld_wr_en;
    logic [bwt_pkg::ROW_IDX_W-1:0] vld_wr_addr;
    logic [bwt_pkg::ROW_W-1:0]     vld_wr_data;

    // request decode
    logic                          accept;
    logic                          out_free;
    logic                          in_inside;
    logic                          req_inside;
    logic [bwt_pkg::ADDR_W-1:0]    start_addr;
    logic [bwt_pkg::ROW_W-1:0]     bit_onehot;
    logic                          was_valid;
    bwt_pkg::entry_t               new_entry;

    // search datapath
    logic                          is_next;
    logic [bwt_pkg::ROW_W-1:0]     next_mask;
    logic [bwt_pkg::ROW_W-1:0]     prev_mask;
    logic [bwt_pkg::ROW_W-1:0]     scan_hits;
    logic                          scan_any;
    logic [bwt_pkg::BIT_IDX_W-1:0] scan_bit;
    logic                          scan_last;
    logic [bwt_pkg::ROW_IDX_W-1:0] row_step;

    bwt_ram #(
        .WIDTH (bwt_pkg::ENTRY_W),
        .DEPTH (bwt_pkg::TABLE_DEPTH)
    ) u_entry_ram (
        .clk     (clk),
        .wr_en   (data_wr_en),
        .wr_addr (data_wr_addr),
        .wr_data (data_wr),
        .rd_en   (data_rd_en),
        .rd_addr (data_rd_addr),
        .rd_data (data_rd)
    );

    bwt_ram #(
        .WIDTH (bwt_pkg::ROW_W),
        .DEPTH (bwt_pkg::ROWS)
    ) u_valid_ram (
        .clk     (clk),
        .wr_en   (vld_wr_en),
        .wr_addr (vld_wr_addr),
        .wr_data (vld_wr_data),
        .rd_en   (vld_rd_en),
        .rd_addr (vld_rd_addr),
        .rd_data (vld_rd)
    );

    assign in_ready  = (state_reg == ST_IDLE);
    assign accept    = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

    assign in_inside  = {1'b0, in_word.address} < bwt_pkg::SPACE_LIMIT;
    assign req_inside = {1'b0, req_reg.address} < bwt_pkg::SPACE_LIMIT;

    // previous search from beyond the space starts at its last address
    assign start_addr = (in_word.action == bwt_pkg::ACT_PREV && !in_inside) ?
                        bwt_pkg::LAST_ADDR : in_word.address;

    assign bit_onehot = bwt_pkg::ROW_W'(1) << req_reg.address[bwt_pkg::BIT_IDX_W-1:0];
    assign was_valid  = req_inside && vld_rd[req_reg.address[bwt_pkg::BIT_IDX_W-1:0]];

    assign new_entry = '{types: req_reg.access_types,
                         mask:  req_reg.match_mask,
                         value: req_reg.match_value,
                         cond:  req_reg.match_condition};

    // search: vld_rd holds the row named by row_reg
    assign is_next   = (req_reg.action == bwt_pkg::ACT_NEXT);
    assign next_mask = (first_reg ? bwt_pkg::ge_mask(start_bit_reg) : '1)
                     & ((row_reg == bwt_pkg::LAST_ROW) ? bwt_pkg::le_mask(bwt_pkg::LAST_BIT)
                                                       : '1)
                     & {bwt_pkg::ROW_W{req_inside}};
    assign prev_mask = first_reg ? bwt_pkg::le_mask(start_bit_reg) : '1;
    assign scan_hits = vld_rd & (is_next ? next_mask : prev_mask);
    assign scan_any  = |scan_hits;
    assign scan_bit  = is_next ? bwt_pkg::lowest_set(scan_hits)
                               : bwt_pkg::highest_set(scan_hits);
    assign scan_last = is_next ? (row_reg == bwt_pkg::LAST_ROW || !req_inside)
                               : (row_reg == '0);
    assign row_step  = is_next ? row_reg + 1'b1 : row_reg - 1'b1;

    always_comb
    begin
        state_next     = state_reg;
        req_next       = req_reg;
        row_next       = row_reg;
        start_bit_next = start_bit_reg;
        first_next     = first_reg;
        total_next     = total_reg;
        exec_next      = exec_reg;
        read_next      = read_reg;
        write_next     = write_reg;
        out_load       = 1'b0;
        out_word_next  = '0;

        data_rd_en   = 1'b0;
        data_rd_addr = in_word.address;
        data_wr_en   = 1'b0;
        data_wr_addr = req_reg.address;
        data_wr      = new_entry;

        vld_rd_en   = 1'b0;
        vld_rd_addr = start_addr[bwt_pkg::ADDR_W-1:bwt_pkg::BIT_IDX_W];
        vld_wr_en   = 1'b0;
        vld_wr_addr = req_reg.address[bwt_pkg::ADDR_W-1:bwt_pkg::BIT_IDX_W];
        vld_wr_data = vld_rd | bit_onehot;

        unique case (state_reg)
            ST_INIT:
            begin
                vld_wr_en   = 1'b1;
                vld_wr_addr = row_reg;
                vld_wr_data = '0;
                row_next    = row_reg + 1'b1;
                if (row_reg == bwt_pkg::CLEAR_LAST_ROW)
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                if (accept)
                begin
                    req_next       = in_word;
                    data_rd_en     = 1'b1;
                    vld_rd_en      = 1'b1;
                    row_next       = start_addr[bwt_pkg::ADDR_W-1:bwt_pkg::BIT_IDX_W];
                    start_bit_next = start_addr[bwt_pkg::BIT_IDX_W-1:0];
                    first_next     = 1'b1;
                    priority if (in_word.action == bwt_pkg::ACT_CLEAR)
                    begin
                        state_next = ST_CLEAR;
                        row_next   = '0;
                    end
                    else if (in_word.action == bwt_pkg::ACT_NEXT ||
                             in_word.action == bwt_pkg::ACT_PREV)
                    begin
                        state_next = ST_SCAN;
                    end
                    else
                    begin
                        state_next = ST_OP;
                    end
                end
            end

            ST_OP:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                    unique case (req_reg.action)
                        bwt_pkg::ACT_CHECK:
                        begin
                            out_word_next.hit = was_valid &&
                                bwt_pkg::cond_holds(data_rd, req_reg.access_value);
                        end
                        bwt_pkg::ACT_ADD:
                        begin
                            if (req_inside)
                            begin
                                // replace: old types withdrawn, total kept
                                data_wr_en  = 1'b1;
                                vld_wr_en   = 1'b1;
                                vld_wr_data = vld_rd | bit_onehot;
                                total_next  = total_reg + bwt_pkg::COUNT_W'(!was_valid);
                                exec_next   = bwt_pkg::count_adjust(exec_reg,
                                    new_entry.types[0], was_valid && data_rd.types[0]);
                                read_next   = bwt_pkg::count_adjust(read_reg,
                                    new_entry.types[1], was_valid && data_rd.types[1]);
                                write_next  = bwt_pkg::count_adjust(write_reg,
                                    new_entry.types[2], was_valid && data_rd.types[2]);
                            end
                        end
                        bwt_pkg::ACT_REMOVE:
                        begin
                            if (was_valid)
                            begin
                                vld_wr_en   = 1'b1;
                                vld_wr_data = vld_rd & ~bit_onehot;
                                total_next  = total_reg - 1'b1;
                                exec_next   = bwt_pkg::count_adjust(exec_reg, 1'b0,
                                                                    data_rd.types[0]);
                                read_next   = bwt_pkg::count_adjust(read_reg, 1'b0,
                                                                    data_rd.types[1]);
                                write_next  = bwt_pkg::count_adjust(write_reg, 1'b0,
                                                                    data_rd.types[2]);
                                out_word_next.found           = 1'b1;
                                out_word_next.entry_condition = data_rd.cond;
                                out_word_next.entry_value     = data_rd.value;
                                out_word_next.entry_mask      = data_rd.mask;
                                out_word_next.entry_types     = data_rd.types;
                            end
                        end
                        default:
                        begin
                            // unknown action: counts only
                        end
                    endcase
                end
            end

            ST_SCAN:
            begin
                if (scan_any || scan_last)
                begin
                    // only the final row waits for the result register
                    if (out_free)
                    begin
                        out_load   = 1'b1;
                        state_next = ST_IDLE;
                        out_word_next.found         = scan_any;
                        out_word_next.found_address = scan_any ? {row_reg, scan_bit} : '0;
                    end
                end
                else
                begin
                    vld_rd_en   = 1'b1;
                    vld_rd_addr = row_step;
                    row_next    = row_step;
                    first_next  = 1'b0;
                end
            end

            ST_CLEAR:
            begin
                // the last row waits for the result register
                if (row_reg != bwt_pkg::CLEAR_LAST_ROW || out_free)
                begin
                    vld_wr_en   = 1'b1;
                    vld_wr_addr = row_reg;
                    vld_wr_data = '0;
                    row_next    = row_reg + 1'b1;
                    if (row_reg == bwt_pkg::CLEAR_LAST_ROW)
                    begin
                        total_next = '0;
                        exec_next  = '0;
                        read_next  = '0;
                        write_next = '0;
                        out_load   = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = ST_INIT;
            end
        endcase

        out_word_next.total_count   = total_next;
        out_word_next.execute_count = exec_next;
        out_word_next.read_count    = read_next;
        out_word_next.write_count   = write_next;
    end

    assign out_valid_next = out_load || (out_valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_INIT;
            row_reg       <= '0;
            start_bit_reg <= '0;
            first_reg     <= 1'b0;
            total_reg     <= '0;
            exec_reg      <= '0;
            read_reg      <= '0;
            write_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            row_reg       <= row_next;
            start_bit_reg <= start_bit_next;
            first_reg     <= first_next;
            total_reg     <= total_next;
            exec_reg      <= exec_next;
            read_reg      <= read_next;
            write_reg     <= write_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        req_reg <= req_next;
        if (out_load)
        begin
            out_word_reg <= out_word_next;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/bwt_checker.sv -----
// port-level checker for the breakpoint watch table, bound to the top level
// depends on bwt_pkg and breakpoint_watch_table_unit_macros.svh
`default_nettype none
`include "breakpoint_watch_table_unit_macros.svh"

module bwt_checker (
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               in_valid,
    input wire logic               in_ready,
    input wire logic               out_valid,
    input wire logic               out_ready,
    input wire bwt_pkg::out_word_t out_word
);

    // a result waiting for out_ready holds its word
    `BWT_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_word), "result word changed while stalled")

    // a hit needs at least one valid entry and never comes with found
    `BWT_ASSERT_NOW(a_hit_needs_entry, clk, rst_n, out_valid && out_word.hit, !out_word.found && out_word.total_count != 0, "hit without a valid entry")

    // a nonzero found address only comes with found
    `BWT_ASSERT_NOW(a_addr_needs_found, clk, rst_n, out_valid && out_word.found_address != 0, out_word.found, "found address without found")

    // one word at a time: busy right after an accept
    `BWT_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready, "accepted a word while busy")

endmodule

bind breakpoint_watch_table_unit bwt_checker u_bwt_checker (.*);

`default_nettype wire

// ----- tb/tb.sv -----
// self-checking bench for breakpoint_watch_table_unit: directed cases, then random traffic
// under four idle profiles; depends on bwt_pkg and the rtl of the table unit
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    // codes the package does not name
    localparam logic [2:0] ACT_SPARE_LO = 3'd6;
    localparam logic [2:0] ACT_SPARE_HI = 3'd7;
    localparam logic [2:0] COND_NEVER   = 3'd7;
    localparam logic [2:0] TYPE_NONE    = 3'b000;
    localparam logic [2:0] TYPE_EXEC    = 3'b001;
    localparam logic [2:0] TYPE_READ    = 3'b010;
    localparam logic [2:0] TYPE_WRITE   = 3'b100;
    localparam logic [2:0] TYPE_ALL     = TYPE_EXEC | TYPE_READ | TYPE_WRITE;

    localparam int     MAX_IDLE_RUN  = 16;
    localparam int     DRAIN_CYCLES  = 64;
    localparam int     WINDOW_SPAN   = 64;
    localparam int     WIDE_SPAN     = 1024;
    localparam int     BLOCK_SHIFT   = 8;
    localparam int     PHASE_WORDS   = 300;
    // worst case is dominated by full-table searches and clears
    localparam longint CYCLE_LIMIT   = 3_000_000;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    bwt_pkg::in_word_t  in_word;
    logic               out_valid;
    logic               out_ready;
    bwt_pkg::out_word_t out_word;

    breakpoint_watch_table_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_word   (in_word),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_word  (out_word)
    );

    // shadow copy of the table
    bit                          valid_mark [bwt_pkg::TABLE_DEPTH];
    bwt_pkg::entry_t             stored     [bwt_pkg::TABLE_DEPTH];
    // live entries per 256-address block, lets searches skip empty stretches
    int unsigned                 block_fill [bwt_pkg::TABLE_DEPTH >> BLOCK_SHIFT];
    logic [bwt_pkg::COUNT_W-1:0] live_entries  = '0;
    logic [bwt_pkg::COUNT_W-1:0] exec_entries  = '0;
    logic [bwt_pkg::COUNT_W-1:0] read_entries  = '0;
    logic [bwt_pkg::COUNT_W-1:0] write_entries = '0;

    // result words still owed by the unit, oldest first
    bwt_pkg::out_word_t pending_results [$];
    bwt_pkg::out_word_t want_word;

    int     fail_count         = 0;
    int     results_seen       = 0;
    int     hit_tally          = 0;
    int     action_tally [8];
    int     sender_idle_pct    = 0;
    int     receiver_stall_pct = 0;
    int     stall_run          = 0;
    int     window_base        = 0;
    longint cycle_count        = 0;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // shadow table
    // ------------------------------------------------------------------

    // threshold is value AND mask; condition seven never fires
    function automatic logic access_matches(input bwt_pkg::entry_t e, input logic [7:0] data);
        logic [7:0] thr;
        thr = e.value & e.mask;
        unique case (e.cond)
            bwt_pkg::COND_GT:     return data > thr;
            bwt_pkg::COND_LT:     return data < thr;
            bwt_pkg::COND_GE:     return data >= thr;
            bwt_pkg::COND_LE:     return data <= thr;
            bwt_pkg::COND_EQ:     return data == thr;
            bwt_pkg::COND_NE:     return data != thr;
            bwt_pkg::COND_ALWAYS: return 1'b1;
            default:              return 1'b0;
        endcase
    endfunction

    function automatic void move_type_counts(input logic [2:0] types, input bit up);
        if (types & TYPE_EXEC)
            exec_entries = up ? exec_entries + 1'b1 : exec_entries - 1'b1;
        if (types & TYPE_READ)
            read_entries = up ? read_entries + 1'b1 : read_entries - 1'b1;
        if (types & TYPE_WRITE)
            write_entries = up ? write_entries + 1'b1 : write_entries - 1'b1;
    endfunction

    // applies one accepted word to the shadow table and returns the result it owes
    function automatic bwt_pkg::out_word_t apply_to_table(input bwt_pkg::in_word_t w);
        bwt_pkg::out_word_t r;
        int                 a;
        int                 i;
        r = '0;
        a = int'(w.address);
        unique case (w.action)
            bwt_pkg::ACT_CHECK:
            begin
                if (valid_mark[a])
                    r.hit = access_matches(stored[a], w.access_value);
            end
            bwt_pkg::ACT_ADD:
            begin
                // replacing an entry withdraws its old type flags, total unchanged
                if (valid_mark[a])
                    move_type_counts(stored[a].types, 1'b0);
                else
                begin
                    live_entries = live_entries + 1'b1;
                    block_fill[a >> BLOCK_SHIFT]++;
                end
                stored[a].cond  = w.match_condition;
                stored[a].value = w.match_value;
                stored[a].mask  = w.match_mask;
                stored[a].types = w.access_types;
                valid_mark[a]   = 1'b1;
                move_type_counts(w.access_types, 1'b1);
            end
            bwt_pkg::ACT_REMOVE:
            begin
                if (valid_mark[a])
                begin
                    r.found           = 1'b1;
                    r.entry_condition = stored[a].cond;
                    r.entry_value     = stored[a].value;
                    r.entry_mask      = stored[a].mask;
                    r.entry_types     = stored[a].types;
                    move_type_counts(stored[a].types, 1'b0);
                    valid_mark[a] = 1'b0;
                    block_fill[a >> BLOCK_SHIFT]--;
                    live_entries = live_entries - 1'b1;
                end
            end
            bwt_pkg::ACT_NEXT:
            begin
                i = a;
                while (i < int'(bwt_pkg::TABLE_DEPTH) && !r.found)
                begin
                    if (block_fill[i >> BLOCK_SHIFT] == 0)
                        i = ((i >> BLOCK_SHIFT) + 1) << BLOCK_SHIFT;
                    else if (valid_mark[i])
                    begin
                        r.found         = 1'b1;
                        r.found_address = i[bwt_pkg::ADDR_W-1:0];
                    end
                    else
                        i++;
                end
            end
            bwt_pkg::ACT_PREV:
            begin
                i = a;
                while (i >= 0 && !r.found)
                begin
                    if (block_fill[i >> BLOCK_SHIFT] == 0)
                        i = ((i >> BLOCK_SHIFT) << BLOCK_SHIFT) - 1;
                    else if (valid_mark[i])
                    begin
                        r.found         = 1'b1;
                        r.found_address = i[bwt_pkg::ADDR_W-1:0];
                    end
                    else
                        i--;
                end
            end
            bwt_pkg::ACT_CLEAR:
            begin
                // stored data stays but is unreachable
                foreach (valid_mark[k])
                    valid_mark[k] = 1'b0;
                foreach (block_fill[k])
                    block_fill[k] = 0;
                live_entries  = '0;
                exec_entries  = '0;
                read_entries  = '0;
                write_entries = '0;
            end
            default:
            begin
                // spare codes leave the table alone, only counts come back
            end
        endcase
        r.total_count   = live_entries;
        r.execute_count = exec_entries;
        r.read_count    = read_entries;
        r.write_count   = write_entries;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // input side
    // ------------------------------------------------------------------

    function automatic bwt_pkg::in_word_t make_word(input logic [2:0] act,
                                                    input logic [15:0] addr,
                                                    input logic [7:0] data,
                                                    input logic [2:0] cond,
                                                    input logic [7:0] value,
                                                    input logic [7:0] mask,
                                                    input logic [2:0] types);
        bwt_pkg::in_word_t w;
        w.action          = act;
        w.address         = addr;
        w.access_value    = data;
        w.match_condition = cond;
        w.match_value     = value;
        w.match_mask      = mask;
        w.access_types    = types;
        return w;
    endfunction

    // valid stays up from one word to the next unless a gap is drawn;
    // the caller lowers it after the last word
    task automatic send_word(input bwt_pkg::in_word_t w);
        int                 gap;
        bwt_pkg::out_word_t owed;
        gap = 0;
        while (gap < MAX_IDLE_RUN && $urandom_range(99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
            gap++;
        end
        in_valid <= 1'b1;
        in_word  <= w;
        do
            @(posedge clk);
        while (!in_ready);
        // accepted at this edge: predict now, in acceptance order
        owed = apply_to_table(w);
        pending_results.push_back(owed);
        action_tally[w.action]++;
        if (owed.hit)
            hit_tally++;
    endtask

    // ------------------------------------------------------------------
    // output side: one checker for every result word
    // ------------------------------------------------------------------

    task automatic compare_field(input string field, input logic [31:0] want,
                                 input logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, field, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (pending_results.size() == 0)
                begin
                    $display("%0t ns: unexpected result word, expected none, got %h",
                             $time, out_word);
                    fail_count++;
                end
                else
                begin
                    want_word = pending_results.pop_front();
                    compare_field("hit", 32'(want_word.hit), 32'(out_word.hit));
                    compare_field("found", 32'(want_word.found), 32'(out_word.found));
                    compare_field("found_address", 32'(want_word.found_address),
                                  32'(out_word.found_address));
                    compare_field("entry_condition", 32'(want_word.entry_condition),
                                  32'(out_word.entry_condition));
                    compare_field("entry_value", 32'(want_word.entry_value),
                                  32'(out_word.entry_value));
                    compare_field("entry_mask", 32'(want_word.entry_mask),
                                  32'(out_word.entry_mask));
                    compare_field("entry_types", 32'(want_word.entry_types),
                                  32'(out_word.entry_types));
                    compare_field("total_count", 32'(want_word.total_count),
                                  32'(out_word.total_count));
                    compare_field("execute_count", 32'(want_word.execute_count),
                                  32'(out_word.execute_count));
                    compare_field("read_count", 32'(want_word.read_count),
                                  32'(out_word.read_count));
                    compare_field("write_count", 32'(want_word.write_count),
                                  32'(out_word.write_count));
                    results_seen++;
                end
            end
            // draw next cycle's ready, stall runs are capped
            if (stall_run < MAX_IDLE_RUN && $urandom_range(99) < receiver_stall_pct)
            begin
                out_ready <= 1'b0;
                stall_run++;
            end
            else
            begin
                out_ready <= 1'b1;
                stall_run = 0;
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("%0t ns: timeout, %0d result words still owed", $time,
                     pending_results.size());
            $display("** breakpoint_watch_table_unit: FAILED **");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // first and last address, condition seven, replacing an entry
    task automatic test_table_extremes();
        send_word(make_word(bwt_pkg::ACT_ADD, 16'h0000, 8'h00, bwt_pkg::COND_GT, 8'hFF,
                            8'h0F, TYPE_ALL));
        send_word(make_word(bwt_pkg::ACT_ADD, 16'hFFFF, 8'hFF, COND_NEVER, 8'h00, 8'h00,
                            TYPE_NONE));
        // 0xff above the masked threshold 0x0f
        send_word(make_word(bwt_pkg::ACT_CHECK, 16'h0000, 8'hFF, bwt_pkg::COND_GT, 8'h00,
                            8'h00, TYPE_NONE));
        // condition seven never fires
        send_word(make_word(bwt_pkg::ACT_CHECK, 16'hFFFF, 8'hFF, bwt_pkg::COND_GT, 8'h00,
                            8'h00, TYPE_NONE));
        // replace: type counts move, total stays
        send_word(make_word(bwt_pkg::ACT_ADD, 16'h0000, 8'h00, bwt_pkg::COND_ALWAYS, 8'h00,
                            8'hFF, TYPE_READ));
    endtask

    // one entry per condition, each checked right at its threshold
    task automatic test_match_conditions();
        logic [15:0] addr;
        for (int c = bwt_pkg::COND_GT; c <= bwt_pkg::COND_ALWAYS; c++)
        begin
            addr = 16'h2000 + 16'(c);
            send_word(make_word(bwt_pkg::ACT_ADD, addr, 8'h00, 3'(c), 8'hA5, 8'h3C,
                                3'(c + 1)));
            send_word(make_word(bwt_pkg::ACT_CHECK, addr, 8'h24, bwt_pkg::COND_GT, 8'h00,
                                8'h00, TYPE_NONE));
        end
    endtask

    task automatic test_remove_and_search();
        send_word(make_word(bwt_pkg::ACT_REMOVE, 16'h0000, 8'h00, bwt_pkg::COND_GT, 8'h00,
                            8'h00, TYPE_NONE));
        // second remove finds nothing
        send_word(make_word(bwt_pkg::ACT_REMOVE, 16'h0000, 8'h00, bwt_pkg::COND_GT, 8'h00,
                            8'h00, TYPE_NONE));
        send_word(make_word(bwt_pkg::ACT_NEXT, 16'h0001, 8'h00, bwt_pkg::COND_GT, 8'h00,
                            8'h00, TYPE_NONE));
        // downward from below the condition block: scans to zero and misses
        send_word(make_word(bwt_pkg::ACT_PREV, 16'h1FFF, 8'h00, bwt_pkg::COND_GT, 8'h00,
                            8'h00, TYPE_NONE));
        send_word(make_word(bwt_pkg::ACT_PREV, 16'hFFFE, 8'h00, bwt_pkg::COND_GT, 8'h00,
                            8'h00, TYPE_NONE));
    endtask

    task automatic test_spare_actions_and_clear();
        send_word(make_word(ACT_SPARE_LO, 16'h2000, 8'h24, bwt_pkg::COND_EQ, 8'h5A, 8'hFF,
                            TYPE_ALL));
        send_word(make_word(ACT_SPARE_HI, 16'hFFFF, 8'hFF, COND_NEVER, 8'hFF, 8'hFF,
                            TYPE_ALL));
        send_word(make_word(bwt_pkg::ACT_CLEAR, 16'h0000, 8'h00, bwt_pkg::COND_GT, 8'h00,
                            8'h00, TYPE_NONE));
        // empty table: the search runs the whole space
        send_word(make_word(bwt_pkg::ACT_NEXT, 16'h0000, 8'h00, bwt_pkg::COND_GT, 8'h00,
                            8'h00, TYPE_NONE));
    endtask

    // mostly a small busy window so entries get added, replaced, hit and removed;
    // a wider ring and the full space for the rest
    function automatic bwt_pkg::in_word_t random_word();
        bwt_pkg::in_word_t w;
        int                pick;
        logic [7:0]        thr;
        pick = $urandom_range(99);
        if (pick < 40)
            w.action = bwt_pkg::ACT_CHECK;
        else if (pick < 70)
            w.action = bwt_pkg::ACT_ADD;
        else if (pick < 84)
            w.action = bwt_pkg::ACT_REMOVE;
        else if (pick < 89)
            w.action = bwt_pkg::ACT_NEXT;
        else if (pick < 94)
            w.action = bwt_pkg::ACT_PREV;
        else if (pick < 95)
            w.action = bwt_pkg::ACT_CLEAR;
        else
            w.action = $urandom_range(1) ? ACT_SPARE_HI : ACT_SPARE_LO;

        pick = $urandom_range(9);
        if (pick < 7)
            w.address = 16'(window_base + $urandom_range(WINDOW_SPAN - 1));
        else if (pick < 9)
            w.address = 16'(window_base + $urandom_range(WIDE_SPAN - 1));
        else
            w.address = 16'($urandom);

        w.access_value    = 8'($urandom);
        w.match_condition = 3'($urandom);
        w.match_value     = 8'($urandom);
        w.match_mask      = 8'($urandom);
        w.access_types    = 3'($urandom);

        // aim half the checks on live entries at the threshold edges
        if (w.action == bwt_pkg::ACT_CHECK && valid_mark[w.address] && $urandom_range(1))
        begin
            thr = stored[w.address].value & stored[w.address].mask;
            w.access_value = thr + 8'($urandom_range(2)) - 8'd1;
        end
        return w;
    endfunction

    task automatic test_random_traffic(input int send_pct, input int stall_pct,
                                       input int words);
        bwt_pkg::in_word_t w;
        int                sent;
        sender_idle_pct    = send_pct;
        receiver_stall_pct = stall_pct;
        window_base        = $urandom_range(int'(bwt_pkg::TABLE_DEPTH) - WIDE_SPAN);
        sent = 0;
        while (sent < words)
        begin
            w = random_word();
            send_word(w);
            // spare codes are not counted
            if (w.action <= bwt_pkg::ACT_CLEAR)
                sent++;
        end
    endtask

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------

    initial
    begin
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_word   = '0;
        out_ready = 1'b0;
        foreach (action_tally[k])
            action_tally[k] = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // directed part runs with no idling; the clearing sweep holds in_ready low
        test_table_extremes();
        test_match_conditions();
        test_remove_and_search();
        test_spare_actions_and_clear();

        test_random_traffic(0, 0, PHASE_WORDS);
        test_random_traffic(74, 0, PHASE_WORDS);
        test_random_traffic(0, 74, PHASE_WORDS);
        test_random_traffic(38, 38, PHASE_WORDS);
        in_valid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        // catch any stray word after the last one owed
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("run: %0d checks (%0d hits), %0d adds, %0d removes, %0d searches, %0d clears",
                 action_tally[bwt_pkg::ACT_CHECK], hit_tally, action_tally[bwt_pkg::ACT_ADD],
                 action_tally[bwt_pkg::ACT_REMOVE],
                 action_tally[bwt_pkg::ACT_NEXT] + action_tally[bwt_pkg::ACT_PREV],
                 action_tally[bwt_pkg::ACT_CLEAR]);
        $display("     %0d result words compared over four idle profiles, %0d mismatches",
                 results_seen, fail_count);
        if (fail_count == 0)
            $display("** breakpoint_watch_table_unit: PASSED **");
        else
            $display("** breakpoint_watch_table_unit: FAILED **");
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+hdl
hdl/bwt_pkg.sv
hdl/bwt_ram.sv
hdl/breakpoint_watch_table_unit.sv
hdl/bwt_checker.sv
tb/tb.sv
